// ----- rtl/cfd_pkg.sv -----
// Shared types and constants for the CRC framed packet deframer.
package cfd_pkg;

    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [1:0] REG_MAGIC_FIRST  = 2'd0;
    localparam logic [1:0] REG_MAGIC_SECOND = 2'd1;
    localparam logic [1:0] REG_CRC_SEED     = 2'd2;
    localparam logic [1:0] REG_MAX_LEN      = 2'd3;

    localparam logic [7:0]  MAGIC_RESET   = 8'h00;
    localparam logic [15:0] SEED_RESET    = 16'hFFFF;
    localparam logic [10:0] MAX_LEN_RESET = 11'd1024;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef struct packed {
        logic [7:0]  magic_first;
        logic [7:0]  magic_second;
        logic [15:0] crc_seed;
        logic [10:0] max_payload_len;
    } cfg_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_FRAME_OK  = 2'd1,
        KIND_LEN_ERROR = 2'd2,
        KIND_CRC_ERROR = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        PH_HUNT0   = 4'd0,
        PH_HUNT1   = 4'd1,
        PH_LEN_LO  = 4'd2,
        PH_LEN_HI  = 4'd3,
        PH_TYPE    = 4'd4,
        PH_SEQ     = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CRC_LO  = 4'd7,
        PH_CRC_HI  = 4'd8
    } phase_t;

endpackage

// ----- rtl/cfd_regs.sv -----
// APB configuration registers for the deframer.
module cfd_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cfd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [cfd_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [cfd_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output cfd_pkg::cfg_t                   cfg
);
    import cfd_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic_first     <= MAGIC_RESET;
            cfg_reg.magic_second    <= MAGIC_RESET;
            cfg_reg.crc_seed        <= SEED_RESET;
            cfg_reg.max_payload_len <= MAX_LEN_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MAGIC_FIRST:  cfg_reg.magic_first     <= pwdata[7:0];
                REG_MAGIC_SECOND: cfg_reg.magic_second    <= pwdata[7:0];
                REG_CRC_SEED:     cfg_reg.crc_seed        <= pwdata[15:0];
                REG_MAX_LEN:      cfg_reg.max_payload_len <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MAGIC_FIRST:  prdata = {24'd0, cfg_reg.magic_first};
            REG_MAGIC_SECOND: prdata = {24'd0, cfg_reg.magic_second};
            REG_CRC_SEED:     prdata = {16'd0, cfg_reg.crc_seed};
            REG_MAX_LEN:      prdata = {21'd0, cfg_reg.max_payload_len};
            default:          prdata = '0;
        endcase
    end

endmodule

// ----- rtl/crc_framed_packet_deframer.sv -----
// Top level: byte-stream deframer for length-prefixed frames with CRC-16/CCITT.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    s_rx_byte
//   m_       out        m_valid/m_ready    m_kind, m_data_out, m_msg_type, m_seq_num,
//                                          m_frame_len, m_end_of_frame
//   APB      in         psel/penable/...   magic_first, magic_second, crc_seed, max_len
//
// One byte is taken per cycle; the phase step and byte-wide CRC update run in the
// same cycle as the transfer and the result lands in the output register.
// A byte is taken while the output register is empty or being drained, so a
// stalled m_ready holds input after one pending result.
// aresetn is synchronous: phase returns to hunting and the output register empties.
module crc_framed_packet_deframer #(
    parameter int unsigned MAX_PAYLOAD = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_rx_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output cfd_pkg::kind_t                  m_kind,
    output logic [7:0]                      m_data_out,
    output logic [7:0]                      m_msg_type,
    output logic [7:0]                      m_seq_num,
    output logic [10:0]                     m_frame_len,
    output logic                            m_end_of_frame,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cfd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [cfd_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [cfd_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import cfd_pkg::*;

    localparam logic [15:0] MaxPayload = 16'(MAX_PAYLOAD);

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    cfg_t cfg;

    cfd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    phase_t      phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic [10:0] length_reg, length_next;
    logic [10:0] left_reg, left_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  hold_reg, hold_next;

    logic        m_valid_reg, m_valid_next;
    kind_t       kind_reg, kind_next;
    logic [7:0]  data_reg, data_next;
    logic [7:0]  mtype_reg, mtype_next;
    logic [7:0]  mseq_reg, mseq_next;
    logic [10:0] flen_reg, flen_next;
    logic        eof_reg, eof_next;

    logic        accept;
    logic        emit;
    logic [15:0] crc_upd;
    logic [15:0] wire16;
    logic [15:0] limit;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign crc_upd = crc16_byte(crc_reg, s_rx_byte);
    assign wire16  = {s_rx_byte, hold_reg};
    assign limit   = ({5'd0, cfg.max_payload_len} < MaxPayload) ?
                     {5'd0, cfg.max_payload_len} : MaxPayload;

    always_comb begin
        phase_next  = phase_reg;
        crc_next    = crc_reg;
        length_next = length_reg;
        left_next   = left_reg;
        type_next   = type_reg;
        seq_next    = seq_reg;
        hold_next   = hold_reg;
        emit        = 1'b0;
        kind_next   = KIND_PAYLOAD;
        data_next   = 8'd0;
        mtype_next  = type_reg;
        mseq_next   = seq_reg;
        flen_next   = length_reg;
        eof_next    = 1'b0;
        case (phase_reg)
            PH_HUNT1: begin
                if (s_rx_byte == cfg.magic_second) begin
                    crc_next   = cfg.crc_seed;
                    phase_next = PH_LEN_LO;
                end else begin
                    phase_next = (s_rx_byte == cfg.magic_first) ? PH_HUNT1 : PH_HUNT0;
                end
            end
            PH_LEN_LO: begin
                crc_next   = crc_upd;
                hold_next  = s_rx_byte;
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                crc_next = crc_upd;
                if (wire16 > limit) begin
                    emit       = 1'b1;
                    kind_next  = KIND_LEN_ERROR;
                    mtype_next = 8'd0;
                    mseq_next  = 8'd0;
                    flen_next  = (|wire16[15:11]) ? 11'h7FF : wire16[10:0];
                    eof_next   = 1'b1;
                    phase_next = PH_HUNT0;
                end else begin
                    length_next = wire16[10:0];
                    left_next   = wire16[10:0];
                    phase_next  = PH_TYPE;
                end
            end
            PH_TYPE: begin
                crc_next   = crc_upd;
                type_next  = s_rx_byte;
                phase_next = PH_SEQ;
            end
            PH_SEQ: begin
                crc_next   = crc_upd;
                seq_next   = s_rx_byte;
                phase_next = (left_reg != 11'd0) ? PH_PAYLOAD : PH_CRC_LO;
            end
            PH_PAYLOAD: begin
                crc_next  = crc_upd;
                left_next = left_reg - 11'd1;
                if (left_reg == 11'd1) begin
                    phase_next = PH_CRC_LO;
                end
                emit      = 1'b1;
                kind_next = KIND_PAYLOAD;
                data_next = s_rx_byte;
            end
            PH_CRC_LO: begin
                hold_next  = s_rx_byte;
                phase_next = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                emit       = 1'b1;
                kind_next  = (wire16 == crc_reg) ? KIND_FRAME_OK : KIND_CRC_ERROR;
                eof_next   = 1'b1;
                phase_next = PH_HUNT0;
            end
            default: begin
                phase_next = (s_rx_byte == cfg.magic_first) ? PH_HUNT1 : PH_HUNT0;
            end
        endcase
    end

    always_comb begin
        if (accept && emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT0;
            crc_reg     <= SEED_RESET;
            length_reg  <= '0;
            left_reg    <= '0;
            type_reg    <= '0;
            seq_reg     <= '0;
            hold_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                phase_reg  <= phase_next;
                crc_reg    <= crc_next;
                length_reg <= length_next;
                left_reg   <= left_next;
                type_reg   <= type_next;
                seq_reg    <= seq_next;
                hold_reg   <= hold_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            kind_reg  <= kind_next;
            data_reg  <= data_next;
            mtype_reg <= mtype_next;
            mseq_reg  <= mseq_next;
            flen_reg  <= flen_next;
            eof_reg   <= eof_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = kind_reg;
    assign m_data_out     = data_reg;
    assign m_msg_type     = mtype_reg;
    assign m_seq_num      = mseq_reg;
    assign m_frame_len    = flen_reg;
    assign m_end_of_frame = eof_reg;

endmodule
